[design/pldm_pkg.sv]
`timescale 1ns / 1ps
// Package for the phase-locked DVFS modulator: constants, register indexes and shared types.
// Depends on nothing; every other file of the block imports it.
package pldm_pkg;

    localparam int WINDOW_LEN     = 20;
    localparam int COS_INDEX_BITS = 10;
    localparam int MAX_CORES      = 64;

    localparam int IDX_W    = $clog2(WINDOW_LEN);
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W    = 17 + $clog2(WINDOW_LEN);
    localparam int SUMSQ_W  = 31 + $clog2(WINDOW_LEN);
    localparam int VAR_W    = 31 + 2 * $clog2(WINDOW_LEN);
    localparam int ANGLE_SH = 16 - COS_INDEX_BITS;

    localparam logic [28:0] Q28_ONE = 29'd268435456;
    localparam logic [28:0] POLY_A  = 29'd331168970;
    localparam logic [28:0] POLY_B  = 29'd68093891;
    localparam logic [28:0] POLY_C  = 29'd5600498;
    localparam logic [28:0] POLY_D  = 29'd246762;

    localparam logic [63:0] VOLT_WORD_BASE = 64'h0000_0000_8000_0011;
    localparam logic [18:0] VOLT_RECIP     = 19'd268436;
    localparam int          VOLT_SHIFT     = 26;
    localparam logic [12:0] LOAD_FULL      = 13'd4096;
    localparam logic [23:0] FREQ_RESET     = 24'd4000000;

    typedef enum logic [2:0] {
        REG_MIN_FREQ = 3'd0,
        REG_MAX_FREQ = 3'd1,
        REG_TROUGH   = 3'd2,
        REG_THRESH   = 3'd3,
        REG_CORES    = 3'd4,
        REG_HOT      = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic [23:0]        min_freq;
        logic [23:0]        max_freq;
        logic signed [9:0]  trough;
        logic [14:0]        thresh;
        logic [6:0]         core_count;
        logic [6:0]         hot_cores;
    } cfg_t;

    typedef struct packed {
        logic [15:0] eff_phase;
        logic        locked;
    } item_t;

endpackage

[design/phase_locked_dvfs_modulator.sv]
`timescale 1ns / 1ps
// Top level of the phase-locked DVFS modulator: configuration registers, core masks
// and the front end, queue and back end. Depends on pldm_pkg and the pldm_* modules.
//
// Phase pulses enter through a queue-like port: a transfer happens on a clock edge
// where push is high and full is low. Results leave the same way: the oldest result
// is on the output ports while empty is low and is taken on an edge with pop high.
// The front end runs the window update and lock test through states F_SQR and F_CMP,
// and takes a new pulse only once the queue has taken the last one from F_CMP.
// For a locked pulse the back end uses one shared 30 by 18 bit multiplier, which
// evaluates the cosine polynomial over four Horner steps, each through states B_LO,
// B_HI and B_ACC, and then scales the frequency and offset; an unlocked pulse goes
// from B_IDLE straight to B_DONE.
// A two-entry queue sits between front and back; when the receiver does not pop,
// the result register holds, the queue fills and full then stays high.
// Reset empties the window (fill count and index), clears the sums and lock history,
// restores the register defaults, sets the frequency setpoint to 4 GHz and the offset to zero. No clearing pass.
// Registers are to be written through cfg_write, cfg_index and cfg_data only while no pulse
// is in flight; the block itself does not enforce this.
module phase_locked_dvfs_modulator
    import pldm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        phase,
    input  logic signed [15:0] phase_difference,
    input  logic               upstream_lock,
    input  logic [12:0]        cpu_load,
    output logic               empty,
    input  logic               pop,
    output logic               apply,
    output logic               lock_state,
    output logic [15:0]        effective_phase,
    output logic [23:0]        hot_freq_khz,
    output logic [23:0]        floor_freq_khz,
    output logic signed [9:0]  voltage_offset_mv,
    output logic [63:0]        voltage_word,
    output logic [63:0]        hot_core_mask,
    output logic [63:0]        parked_core_mask,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    cfg_t        cfg_reg;
    item_t       front_item;
    logic        front_valid;
    logic        front_ready;
    item_t       back_item;
    logic        back_valid;
    logic        back_ready;
    logic [10:0] volt_code;
    logic [6:0]  cores;
    logic [6:0]  hot;

    function automatic logic [63:0] low_mask(input logic [6:0] n);
        return (n >= 7'd64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_freq   <= 24'd800000;
            cfg_reg.max_freq   <= 24'd4000000;
            cfg_reg.trough     <= -10'sd50;
            cfg_reg.thresh     <= 15'd410;
            cfg_reg.core_count <= 7'd64;
            cfg_reg.hot_cores  <= 7'd64;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_MIN_FREQ: cfg_reg.min_freq   <= cfg_data;
                REG_MAX_FREQ: cfg_reg.max_freq   <= cfg_data;
                REG_TROUGH:   cfg_reg.trough     <= cfg_data[9:0];
                REG_THRESH:   cfg_reg.thresh     <= cfg_data[14:0];
                REG_CORES:    cfg_reg.core_count <= cfg_data[6:0];
                REG_HOT:      cfg_reg.hot_cores  <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    pldm_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .phase            (phase),
        .phase_difference (phase_difference),
        .upstream_lock    (upstream_lock),
        .cpu_load         (cpu_load),
        .cfg              (cfg_reg),
        .item             (front_item),
        .item_valid       (front_valid),
        .item_ready       (front_ready)
    );

    pldm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (front_item),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .out_item  (back_item),
        .out_valid (back_valid),
        .out_ready (back_ready)
    );

    pldm_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .item              (back_item),
        .item_valid        (back_valid),
        .item_ready        (back_ready),
        .cfg               (cfg_reg),
        .empty             (empty),
        .pop               (pop),
        .apply             (apply),
        .lock_state        (lock_state),
        .effective_phase   (effective_phase),
        .hot_freq_khz      (hot_freq_khz),
        .voltage_offset_mv (voltage_offset_mv),
        .volt_code         (volt_code)
    );

    always_comb
    begin
        if (cfg_reg.core_count == 7'd0)
        begin
            cores = 7'd1;
        end
        else if (cfg_reg.core_count > 7'(MAX_CORES))
        begin
            cores = 7'(MAX_CORES);
        end
        else
        begin
            cores = cfg_reg.core_count;
        end
        if (cfg_reg.hot_cores > cores)
        begin
            hot = cores;
        end
        else if (cfg_reg.hot_cores == 7'd0)
        begin
            hot = 7'd1;
        end
        else
        begin
            hot = cfg_reg.hot_cores;
        end
    end

    assign floor_freq_khz   = cfg_reg.min_freq;
    assign voltage_word     = VOLT_WORD_BASE | {32'd0, volt_code, 21'd0};
    assign hot_core_mask    = low_mask(hot);
    assign parked_core_mask = low_mask(cores) & ~low_mask(hot);

    a_masks_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (hot_core_mask & parked_core_mask) == 64'd0)
        else $error("hot and parked core masks overlap");

    a_lock_applies: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && lock_state) |-> apply)
        else $error("locked result without apply");

    a_front_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front end took a pulse without going busy");

endmodule

[design/pldm_front.sv]
`timescale 1ns / 1ps
// Front end: accepts phase pulses, updates the difference window and qualifies lock.
// Depends on pldm_pkg.
module pldm_front
    import pldm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [15:0]        phase,
    input  logic signed [15:0] phase_difference,
    input  logic               upstream_lock,
    input  logic [12:0]        cpu_load,
    input  cfg_t               cfg,
    output item_t              item,
    output logic               item_valid,
    input  logic               item_ready
);

    typedef enum logic [1:0] {F_IDLE, F_SQR, F_CMP} fstate_t;

    fstate_t                   state_reg;
    logic signed [15:0]        win_reg [WINDOW_LEN];
    logic [IDX_W-1:0]          idx_reg;
    logic [FILL_W-1:0]         fill_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [SUMSQ_W-1:0]        sumsq_reg;
    logic [15:0]               eff_reg;
    logic                      up_reg;
    logic [VAR_W-1:0]          sq_reg;
    logic [VAR_W-1:0]          lhs_reg;
    logic [29:0]               tt_reg;

    logic signed [15:0]        old;
    logic signed [31:0]        pd_sq;
    logic signed [31:0]        old_sq;
    logic [12:0]               load_sat;
    logic [SUM_W-1:0]          mag;
    logic [VAR_W-1:0]          var_val;
    logic [VAR_W-1:0]          lim;
    logic                      window_full;
    logic                      accept;

    assign accept      = push && !full;
    assign full        = (state_reg != F_IDLE);
    assign window_full = (fill_reg >= FILL_W'(WINDOW_LEN));
    assign old         = window_full ? win_reg[idx_reg] : 16'sd0;
    assign pd_sq       = phase_difference * phase_difference;
    assign old_sq      = old * old;
    assign load_sat    = (cpu_load > LOAD_FULL) ? LOAD_FULL : cpu_load;
    assign mag         = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign var_val     = (lhs_reg >= sq_reg) ? (lhs_reg - sq_reg) : '0;
    assign lim         = VAR_W'(tt_reg) * VAR_W'(WINDOW_LEN * WINDOW_LEN);

    assign item_valid     = (state_reg == F_CMP);
    assign item.eff_phase = eff_reg;
    assign item.locked    = up_reg && window_full && (var_val < lim);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            idx_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        win_reg[idx_reg] <= phase_difference;
                        sum_reg   <= sum_reg + SUM_W'(phase_difference) - SUM_W'(old);
                        sumsq_reg <= sumsq_reg + SUMSQ_W'($unsigned(pd_sq))
                                     - SUMSQ_W'($unsigned(old_sq));
                        idx_reg   <= (idx_reg == IDX_W'(WINDOW_LEN - 1)) ? '0 : idx_reg + 1'b1;
                        if (!window_full)
                        begin
                            fill_reg <= fill_reg + 1'b1;
                        end
                        eff_reg   <= phase + 16'({load_sat, 2'b00});
                        up_reg    <= upstream_lock;
                        state_reg <= F_SQR;
                    end
                end
                F_SQR:
                begin
                    sq_reg    <= VAR_W'(mag) * VAR_W'(mag);
                    lhs_reg   <= VAR_W'(sumsq_reg) * VAR_W'(WINDOW_LEN);
                    tt_reg    <= cfg.thresh * cfg.thresh;
                    state_reg <= F_CMP;
                end
                F_CMP:
                begin
                    if (item_ready)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

[design/pldm_queue.sv]
`timescale 1ns / 1ps
// Two-entry queue of classified pulses between the front and back ends.
// Depends on pldm_pkg.
module pldm_queue
    import pldm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t in_item,
    input  logic  in_valid,
    output logic  in_ready,
    output item_t out_item,
    output logic  out_valid,
    input  logic  out_ready
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_wr;
    logic        do_rd;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
            begin
                slot_reg[wr_ptr_reg] <= in_item;
                wr_ptr_reg           <= !wr_ptr_reg;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

[design/pldm_back.sv]
`timescale 1ns / 1ps
// Back end: cosine evaluation on a shared multiplier, setpoint update and result register.
// Depends on pldm_pkg.
module pldm_back
    import pldm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  item_t              item,
    input  logic               item_valid,
    output logic               item_ready,
    input  cfg_t               cfg,
    output logic               empty,
    input  logic               pop,
    output logic               apply,
    output logic               lock_state,
    output logic [15:0]        effective_phase,
    output logic [23:0]        hot_freq_khz,
    output logic signed [9:0]  voltage_offset_mv,
    output logic [10:0]        volt_code
);

    typedef enum logic [3:0] {
        B_IDLE, B_SQ, B_U2, B_LO, B_HI, B_ACC, B_COS,
        B_FMUL, B_OMUL, B_SET, B_VMUL, B_VFIX, B_DONE
    } bstate_t;

    bstate_t                state_reg;
    logic                   res_valid_reg;
    logic                   apply_reg;
    logic                   lock_reg;
    logic                   was_locked_reg;
    logic [15:0]            eff_reg;
    logic [23:0]            freq_reg;
    logic signed [9:0]      off_reg;
    logic [10:0]            code_reg;
    logic [14:0]            t_reg;
    logic                   neg_reg;
    logic [28:0]            u2_reg;
    logic [28:0]            p_reg;
    logic [1:0]             step_reg;
    logic signed [47:0]     mul_p_reg;
    logic signed [47:0]     lo_reg;
    logic signed [47:0]     fprod_reg;
    logic [16:0]            w_reg;
    logic [36:0]            vprod_reg;

    logic signed [29:0]     mul_a;
    logic signed [17:0]     mul_b;
    logic [15:0]            ang;
    logic [58:0]            acc;
    logic signed [32:0]     p_diff;
    logic [28:0]            poly_k;
    logic [28:0]            p_new;
    logic [15:0]            c_round;
    logic [14:0]            c_mag;
    logic signed [47:0]     f_q;
    logic signed [47:0]     o_q;
    logic signed [25:0]     f_sum;
    logic [9:0]             off_mag;
    logic [17:0]            vx;
    logic [11:0]            vq;
    logic [11:0]            vq_fix;
    logic                   start;

    function automatic logic signed [47:0] trunc15(input logic signed [47:0] x);
        logic signed [47:0] biased;
        biased = x + (x[47] ? 48'sd32767 : 48'sd0);
        return biased >>> 15;
    endfunction

    assign item_ready = (state_reg == B_IDLE) && !res_valid_reg;
    assign start      = item_valid && item_ready;

    assign ang = {item.eff_phase[15:ANGLE_SH], ANGLE_SH'(0)};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            B_SQ:
            begin
                mul_a = 30'(t_reg);
                mul_b = 18'(t_reg);
            end
            B_LO:
            begin
                mul_a = 30'(p_reg);
                mul_b = 18'(u2_reg[13:0]);
            end
            B_HI:
            begin
                mul_a = 30'(p_reg);
                mul_b = 18'(u2_reg[28:14]);
            end
            B_FMUL:
            begin
                mul_a = 30'($signed({1'b0, cfg.max_freq}) - $signed({1'b0, cfg.min_freq}));
                mul_b = 18'(w_reg);
            end
            B_OMUL:
            begin
                mul_a = 30'(cfg.trough);
                mul_b = 18'(17'd32768 - w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        case (step_reg)
            2'd0:    poly_k = POLY_C;
            2'd1:    poly_k = POLY_B;
            2'd2:    poly_k = POLY_A;
            default: poly_k = Q28_ONE;
        endcase
    end

    assign acc     = {mul_p_reg[44:0], 14'd0} + 59'($unsigned(lo_reg));
    assign p_diff  = $signed({4'd0, poly_k}) - $signed({2'd0, acc[58:28]});
    assign p_new   = p_diff[32] ? '0 : p_diff[28:0];
    assign c_round = 16'((p_reg + 29'd8192) >> 14);
    assign c_mag   = (c_round > 16'd16384) ? 15'd16384 : c_round[14:0];
    assign f_q     = trunc15(fprod_reg);
    assign o_q     = trunc15(mul_p_reg);
    assign f_sum   = $signed({2'b00, cfg.min_freq}) + 26'(f_q);
    assign off_mag = off_reg[9] ? 10'(-off_reg) : 10'(off_reg);
    assign vx      = {off_mag, 8'd0} + 18'd125;
    assign vq      = 12'(vprod_reg >> VOLT_SHIFT);
    assign vq_fix  = (20'(vq) * 20'd250 > 20'(vx)) ? vq - 12'd1 : vq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            res_valid_reg  <= 1'b0;
            was_locked_reg <= 1'b0;
            freq_reg       <= FREQ_RESET;
            off_reg        <= '0;
            code_reg       <= '0;
            apply_reg      <= 1'b0;
            lock_reg       <= 1'b0;
        end
        else
        begin
            mul_p_reg <= mul_a * mul_b;
            if (res_valid_reg && pop)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (start)
                    begin
                        eff_reg   <= item.eff_phase;
                        lock_reg  <= item.locked;
                        apply_reg <= item.locked || was_locked_reg;
                        t_reg     <= ang[14] ? 15'(15'd16384 - 15'(ang[13:0])) : 15'(ang[13:0]);
                        neg_reg   <= (ang[15] != ang[14]);
                        if (item.locked)
                        begin
                            state_reg <= B_SQ;
                        end
                        else
                        begin
                            if (was_locked_reg)
                            begin
                                freq_reg <= cfg.max_freq;
                                off_reg  <= '0;
                                code_reg <= '0;
                            end
                            state_reg <= B_DONE;
                        end
                    end
                end
                B_SQ:
                begin
                    state_reg <= B_U2;
                end
                B_U2:
                begin
                    u2_reg    <= mul_p_reg[28:0];
                    p_reg     <= POLY_D;
                    step_reg  <= 2'd0;
                    state_reg <= B_LO;
                end
                B_LO:
                begin
                    state_reg <= B_HI;
                end
                B_HI:
                begin
                    lo_reg    <= mul_p_reg;
                    state_reg <= B_ACC;
                end
                B_ACC:
                begin
                    p_reg <= p_new;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= B_COS;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 2'd1;
                        state_reg <= B_LO;
                    end
                end
                B_COS:
                begin
                    w_reg     <= neg_reg ? 17'd16384 + 17'(c_mag) : 17'd16384 - 17'(c_mag);
                    state_reg <= B_FMUL;
                end
                B_FMUL:
                begin
                    state_reg <= B_OMUL;
                end
                B_OMUL:
                begin
                    fprod_reg <= mul_p_reg;
                    state_reg <= B_SET;
                end
                B_SET:
                begin
                    freq_reg  <= f_sum[23:0];
                    off_reg   <= o_q[9:0];
                    state_reg <= B_VMUL;
                end
                B_VMUL:
                begin
                    vprod_reg <= 37'(vx) * 37'(VOLT_RECIP);
                    state_reg <= B_VFIX;
                end
                B_VFIX:
                begin
                    code_reg  <= off_reg[9] ? 11'(-vq_fix) : 11'(vq_fix);
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    was_locked_reg <= lock_reg;
                    res_valid_reg  <= 1'b1;
                    state_reg      <= B_IDLE;
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    assign empty             = !res_valid_reg;
    assign apply             = apply_reg;
    assign lock_state        = lock_reg;
    assign effective_phase   = eff_reg;
    assign hot_freq_khz      = freq_reg;
    assign voltage_offset_mv = off_reg;
    assign volt_code         = code_reg;

endmodule
